/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a same-cycle implication, skipped while reset is asserted
`define OWBM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("owbm check failed");

// Check an implication in the following cycle, skipped while reset is asserted
`define OWBM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("owbm check failed");

`endif

/* rtl/owbm_pkg.sv */
package owbm_pkg;

    localparam int TIMER_BITS_DEF = 10;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 10;
    localparam int LEN_W          = 10;

    localparam logic [2:0] LAST_BIT = 3'd7;

    // Request codes carried by each tick
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_RESET = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_LOW   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_PRES_WAIT   = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_TAIL  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_PULSE  = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_SLOT  = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_SAMPLE = CFG_INDEX_W'(5);
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_TAIL   = CFG_INDEX_W'(6);

    // Register reset values
    localparam logic [9:0] RESET_LOW_DEF   = 10'd480;
    localparam logic [7:0] PRES_WAIT_DEF   = 8'd60;
    localparam logic [9:0] RESET_TAIL_DEF  = 10'd420;
    localparam logic [3:0] SLOT_PULSE_DEF  = 4'd1;
    localparam logic [6:0] WRITE_SLOT_DEF  = 7'd60;
    localparam logic [5:0] READ_SAMPLE_DEF = 6'd14;
    localparam logic [6:0] READ_TAIL_DEF   = 7'd45;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_RLOW    = 4'd1,
        PH_RWAIT   = 4'd2,
        PH_RTAIL   = 4'd3,
        PH_WPULSE  = 4'd4,
        PH_WHOLD   = 4'd5,
        PH_RDPULSE = 4'd6,
        PH_RDWAIT  = 4'd7,
        PH_RDTAIL  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [7:0] presence_wait;
        logic [9:0] reset_tail;
        logic [3:0] slot_pulse;
        logic [6:0] write_slot_time;
        logic [5:0] read_sample_delay;
        logic [6:0] read_tail;
    } cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       no_presence;
        logic [7:0] read_data;
    } result_t;

endpackage

/* rtl/one_wire_bus_master_top.sv */
// Each accepted tick's result is registered in the output register.
// Throughput: one tick per cycle while the output is not stalled; the phase sequencer and timer update in one pass.
// Each tick yields exactly one result; the output register decouples the two sides.
// Reset (aresetn low, synchronous): phase idle, timer and bit count zero,
// presence flag one, read byte zero, registers at their default timings.
module one_wire_bus_master_top
    import owbm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_req_type,
    input  logic [7:0]             s_write_data,
    input  logic                   s_line_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_drive_low,
    output logic                   m_busy_res,
    output logic                   m_done_res,
    output logic                   m_no_presence,
    output logic [7:0]             m_read_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    result_t step_res;
    result_t out_res;
    logic    in_fire;

    assign in_fire = s_valid && s_ready;

    owbm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owbm_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .req        (req_t'(s_req_type)),
        .write_data (s_write_data),
        .line_in    (s_line_in),
        .cfg        (cfg),
        .res        (step_res)
    );

    owbm_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_res   (step_res),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (out_res)
    );

    assign m_drive_low   = out_res.drive_low;
    assign m_busy_res    = out_res.busy_res;
    assign m_done_res    = out_res.done_res;
    assign m_no_presence = out_res.no_presence;
    assign m_read_data   = out_res.read_data;

endmodule

/* rtl/owbm_cfg_regs.sv */
module owbm_cfg_regs
    import owbm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg          = cfg_reg;

    // Decode the write request; ignore unknown indexes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RESET_LOW:   cfg_next.reset_low_time    = cfg_data[9:0];
                CFG_PRES_WAIT:   cfg_next.presence_wait     = cfg_data[7:0];
                CFG_RESET_TAIL:  cfg_next.reset_tail        = cfg_data[9:0];
                CFG_SLOT_PULSE:  cfg_next.slot_pulse        = cfg_data[3:0];
                CFG_WRITE_SLOT:  cfg_next.write_slot_time   = cfg_data[6:0];
                CFG_READ_SAMPLE: cfg_next.read_sample_delay = cfg_data[5:0];
                CFG_READ_TAIL:   cfg_next.read_tail         = cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_time    <= RESET_LOW_DEF;
            cfg_reg.presence_wait     <= PRES_WAIT_DEF;
            cfg_reg.reset_tail        <= RESET_TAIL_DEF;
            cfg_reg.slot_pulse        <= SLOT_PULSE_DEF;
            cfg_reg.write_slot_time   <= WRITE_SLOT_DEF;
            cfg_reg.read_sample_delay <= READ_SAMPLE_DEF;
            cfg_reg.read_tail         <= READ_TAIL_DEF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/owbm_core.sv */
module owbm_core
    import owbm_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  req_t       req,
    input  logic [7:0] write_data,
    input  logic       line_in,
    input  cfg_t       cfg,
    output result_t    res
);

    localparam int CMP_W = (TIMER_BITS + 1 > LEN_W) ? TIMER_BITS + 1 : LEN_W;

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [2:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  presence_reg, presence_next;
    logic [7:0]            last_read_reg, last_read_next;

    phase_t                cur_phase;
    logic [TIMER_BITS-1:0] cur_timer;
    logic [2:0]            cur_bit;
    logic [7:0]            cur_shift;

    logic [LEN_W-1:0]      len;
    logic [CMP_W-1:0]      timer_inc;
    logic                  tick_end;
    logic                  first_tick;
    logic                  last_bit;
    logic [TIMER_BITS-1:0] timer_after;
    logic [7:0]            rd_shift;

    // Start a command on the tick that carries it
    always_comb begin
        cur_phase = phase_reg;
        cur_timer = timer_reg;
        cur_bit   = bit_reg;
        cur_shift = shift_reg;
        if (phase_reg == PH_IDLE) begin
            case (req)
                REQ_RESET: begin
                    cur_phase = PH_RLOW;
                    cur_timer = '0;
                    cur_bit   = '0;
                end
                REQ_WRITE: begin
                    cur_phase = PH_WPULSE;
                    cur_timer = '0;
                    cur_bit   = '0;
                    cur_shift = write_data;
                end
                REQ_READ: begin
                    cur_phase = PH_RDPULSE;
                    cur_timer = '0;
                    cur_bit   = '0;
                    cur_shift = '0;
                end
                default: ;
            endcase
        end
    end

    // Select the length of the running phase
    always_comb begin
        case (cur_phase)
            PH_RLOW:    len = cfg.reset_low_time;
            PH_RWAIT:   len = LEN_W'(cfg.presence_wait);
            PH_RTAIL:   len = cfg.reset_tail;
            PH_WPULSE:  len = LEN_W'(cfg.slot_pulse);
            PH_WHOLD:   len = LEN_W'(cfg.write_slot_time);
            PH_RDPULSE: len = LEN_W'(cfg.slot_pulse);
            PH_RDWAIT:  len = LEN_W'(cfg.read_sample_delay);
            PH_RDTAIL:  len = LEN_W'(cfg.read_tail);
            default:    len = '0;
        endcase
    end

    // End the phase at its length, or when the timer would wrap
    assign timer_inc   = CMP_W'(cur_timer) + CMP_W'(1);
    assign tick_end    = (timer_inc >= CMP_W'(len)) || (&cur_timer);
    assign timer_after = tick_end ? '0 : timer_inc[TIMER_BITS-1:0];
    assign first_tick  = (cur_timer == '0);
    assign last_bit    = (cur_bit == LAST_BIT);
    assign rd_shift    = first_tick ? {line_in, cur_shift[7:1]} : cur_shift;

    // Next state
    always_comb begin
        phase_next     = cur_phase;
        timer_next     = cur_timer;
        bit_next       = cur_bit;
        shift_next     = cur_shift;
        presence_next  = presence_reg;
        last_read_next = last_read_reg;
        unique case (cur_phase)
            PH_IDLE: ;
            PH_RLOW: begin
                timer_next = timer_after;
                if (tick_end) phase_next = PH_RWAIT;
            end
            PH_RWAIT: begin
                timer_next = timer_after;
                if (tick_end) phase_next = PH_RTAIL;
            end
            PH_RTAIL: begin
                if (first_tick) presence_next = line_in;
                timer_next = timer_after;
                if (tick_end) phase_next = PH_IDLE;
            end
            PH_WPULSE: begin
                timer_next = timer_after;
                if (tick_end) phase_next = PH_WHOLD;
            end
            PH_WHOLD: begin
                timer_next = timer_after;
                if (tick_end) begin
                    shift_next = {1'b0, cur_shift[7:1]};
                    if (last_bit) begin
                        bit_next   = '0;
                        phase_next = PH_IDLE;
                    end else begin
                        bit_next   = cur_bit + 3'd1;
                        phase_next = PH_WPULSE;
                    end
                end
            end
            PH_RDPULSE: begin
                timer_next = timer_after;
                if (tick_end) phase_next = PH_RDWAIT;
            end
            PH_RDWAIT: begin
                timer_next = timer_after;
                if (tick_end) phase_next = PH_RDTAIL;
            end
            PH_RDTAIL: begin
                shift_next = rd_shift;
                timer_next = timer_after;
                if (tick_end) begin
                    if (last_bit) begin
                        last_read_next = rd_shift;
                        bit_next       = '0;
                        phase_next     = PH_IDLE;
                    end else begin
                        bit_next   = cur_bit + 3'd1;
                        phase_next = PH_RDPULSE;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
                timer_next = '0;
            end
        endcase
    end

    // Outputs for this tick
    always_comb begin
        res.drive_low   = 1'b0;
        res.busy_res    = 1'b1;
        res.done_res    = 1'b0;
        res.no_presence = presence_next;
        res.read_data   = last_read_next;
        unique case (cur_phase)
            PH_IDLE:    res.busy_res  = 1'b0;
            PH_RLOW:    res.drive_low = 1'b1;
            PH_RWAIT: ;
            PH_RTAIL:   res.done_res  = tick_end;
            PH_WPULSE:  res.drive_low = 1'b1;
            PH_WHOLD: begin
                res.drive_low = ~cur_shift[0];
                res.done_res  = tick_end && last_bit;
            end
            PH_RDPULSE: res.drive_low = 1'b1;
            PH_RDWAIT: ;
            PH_RDTAIL:  res.done_res  = tick_end && last_bit;
            default:    res.busy_res  = 1'b0;
        endcase
    end

    // Advance the state on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            presence_reg  <= 1'b1;
            last_read_reg <= '0;
        end else if (in_fire) begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            presence_reg  <= presence_next;
            last_read_reg <= last_read_next;
        end
    end

endmodule

/* rtl/owbm_out_reg.sv */
module owbm_out_reg
    import owbm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    result_t res_reg;

    // Take a new result whenever the held one leaves or none is held
    assign in_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Load payload on each accepted request
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            res_reg <= in_res;
        end
    end

endmodule

/* rtl/owbm_checker.sv */
`include "assert_macros.svh"

module owbm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_drive_low,
    input logic       m_busy_res,
    input logic       m_done_res,
    input logic [7:0] m_read_data
);

    // A completion tick always belongs to a running operation
    `OWBM_ASSERT_NOW(a_done_busy, aclk, aresetn, m_valid && m_done_res, m_busy_res)

    // The bus is released whenever no operation runs
    `OWBM_ASSERT_NOW(a_idle_release, aclk, aresetn, m_valid && !m_busy_res, !m_drive_low)

    // Input stalls only behind a held, untaken result
    `OWBM_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready, m_valid && !m_ready)

    // A stalled result holds its value
    `OWBM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_read_data) && $stable(m_done_res))

endmodule

bind one_wire_bus_master_top owbm_checker u_owbm_checker (.*);
